/* hw/rtl/blm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blm_pkg
// Shared types, register codes and constants of the battery level monitor.
// ----------------------------------------------------------------------------
package blm_pkg;

   localparam int MV_W              = 16;
   localparam int LEVEL_W           = 4;
   localparam int COUNT_W           = 16;
   localparam int CSR_INDEX_W       = 3;
   localparam int CSR_DATA_W        = 16;

   localparam int NUM_LEVELS_DEFAULT = 10;
   localparam int FULL_PERCENT       = 100;
   localparam int HYST_PERCENT       = 2;

   localparam logic [LEVEL_W-1:0] NO_LEVEL = 4'd15;

   localparam logic [MV_W-1:0]    EMPTY_STANDBY_RESET = 16'd3000;
   localparam logic [MV_W-1:0]    FULL_STANDBY_RESET  = 16'd4200;
   localparam logic [MV_W-1:0]    EMPTY_FLYING_RESET  = 16'd2900;
   localparam logic [MV_W-1:0]    FULL_FLYING_RESET   = 16'd3900;
   localparam logic [COUNT_W-1:0] CHANGE_DELAY_RESET  = 16'd5;

   // register map
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_EMPTY_STANDBY = 3'd0,
      CSR_FULL_STANDBY  = 3'd1,
      CSR_EMPTY_FLYING  = 3'd2,
      CSR_FULL_FLYING   = 3'd3,
      CSR_CHANGE_DELAY  = 3'd4
   } blm_csr_index_type;

   // request kinds
   localparam logic REQ_SAMPLE     = 1'b0;
   localparam logic REQ_DISCONNECT = 1'b1;

   typedef struct packed {
      logic            req_type;
      logic [MV_W-1:0] voltage_mv;
      logic            motors_off;
   } blm_req_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic               level_valid;
      logic               battery_low;
      logic               state_changed;
   } blm_rsp_type;

   typedef struct packed {
      logic [MV_W-1:0]    empty_standby_mv;
      logic [MV_W-1:0]    full_standby_mv;
      logic [MV_W-1:0]    empty_flying_mv;
      logic [MV_W-1:0]    full_flying_mv;
      logic [COUNT_W-1:0] change_delay;
   } blm_cfg_type;

endpackage

/* hw/rtl/blm_csr.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blm_csr
// Configuration registers: voltage windows and the state change delay.
// ----------------------------------------------------------------------------
module blm_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_en,
   input  logic [blm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [blm_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output blm_pkg::blm_cfg_type              cfg
);
   import blm_pkg::*;

   blm_cfg_type cfg_ff;
   blm_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_EMPTY_STANDBY: cfg_in.empty_standby_mv = csr_wdata[MV_W-1:0];
            CSR_FULL_STANDBY:  cfg_in.full_standby_mv  = csr_wdata[MV_W-1:0];
            CSR_EMPTY_FLYING:  cfg_in.empty_flying_mv  = csr_wdata[MV_W-1:0];
            CSR_FULL_FLYING:   cfg_in.full_flying_mv   = csr_wdata[MV_W-1:0];
            CSR_CHANGE_DELAY:  cfg_in.change_delay     = csr_wdata[COUNT_W-1:0];
            default: ;  // unmapped index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.empty_standby_mv <= EMPTY_STANDBY_RESET;
         cfg_ff.full_standby_mv  <= FULL_STANDBY_RESET;
         cfg_ff.empty_flying_mv  <= EMPTY_FLYING_RESET;
         cfg_ff.full_flying_mv   <= FULL_FLYING_RESET;
         cfg_ff.change_delay     <= CHANGE_DELAY_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* hw/rtl/battery_level_monitor_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_level_monitor_core
// Maps a voltage sample onto a 0..NUM_LEVELS battery level with hysteresis
// and tracks a delayed normal/low battery state.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | req_data  (blm_req_type)
//   rsp     | out       | rsp_valid/rsp_stall  | rsp_data  (blm_rsp_type)
//   csr     | in        | csr_write_en         | csr_index, csr_wdata
//
// A sample goes through setup, the scaled-voltage product, then one threshold
// product and one compare per level tested (up to NUM_LEVELS), and the final
// write; one multiplier, SCALE_W by MV_W bits, serves all of these products.
// A disconnect skips to the write. One transaction is in flight at a time.
// Reset (synchronous) restores register defaults and clears the state.
// A stalled result sits in the output register while the next transaction
// is computed; it only waits at the final write.
// ----------------------------------------------------------------------------
module battery_level_monitor_core #(
   parameter int NUM_LEVELS = blm_pkg::NUM_LEVELS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  blm_pkg::blm_req_type              req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output blm_pkg::blm_rsp_type              rsp_data,
   input  logic                              csr_write_en,
   input  logic [blm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [blm_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import blm_pkg::*;

   localparam int LHS_SCALE = FULL_PERCENT * NUM_LEVELS;
   localparam int HYST_STEP = HYST_PERCENT * NUM_LEVELS;
   localparam int SCALE_W   = $clog2(LHS_SCALE + 1);
   localparam int PROD_W    = SCALE_W + MV_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_LHS,
      ST_MUL,
      ST_CMP,
      ST_WRITE
   } state_type;

   blm_cfg_type cfg;

   blm_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   state_type            state_ff,      state_in;
   blm_req_type          req_ff,        req_in;
   logic [MV_W-1:0]      num_ff,        num_in;
   logic [MV_W-1:0]      den_ff,        den_in;
   logic [PROD_W-1:0]    lhs_ff,        lhs_in;
   logic [PROD_W-1:0]    prod_ff,       prod_in;
   logic [SCALE_W-1:0]   base_ff,       base_in;
   logic [LEVEL_W-1:0]   idx_ff,        idx_in;
   logic [LEVEL_W-1:0]   level_ff,      level_in;
   logic [LEVEL_W-1:0]   prev_level_ff, prev_level_in;
   logic                 low_ff,        low_in;
   logic [COUNT_W-1:0]   count_ff,      count_in;
   logic                 rsp_valid_ff,  rsp_valid_in;
   blm_rsp_type          rsp_data_ff,   rsp_data_in;

   // shared multiplier
   logic [SCALE_W-1:0]   mul_a;
   logic [MV_W-1:0]      mul_b;
   logic [PROD_W-1:0]    mul_p;

   logic [MV_W-1:0]      win_empty;
   logic [MV_W-1:0]      win_full;
   logic [MV_W-1:0]      span;
   logic [MV_W-1:0]      offset;
   logic                 count_en;
   logic [COUNT_W-1:0]   count_next;
   logic                 toggle;
   logic                 out_free;

   assign mul_a = (state_ff == ST_LHS) ? SCALE_W'(LHS_SCALE)
                : base_ff + ((prev_level_ff == idx_ff) ? SCALE_W'(HYST_STEP)
                                                       : SCALE_W'(0));
   assign mul_b = (state_ff == ST_LHS) ? num_ff : den_ff;
   assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

   assign win_empty = req_ff.motors_off ? cfg.empty_standby_mv : cfg.empty_flying_mv;
   assign win_full  = req_ff.motors_off ? cfg.full_standby_mv  : cfg.full_flying_mv;
   assign span      = win_full - win_empty;
   assign offset    = req_ff.voltage_mv - win_empty;

   // low/normal state counter
   assign count_en   = (level_ff == LEVEL_W'(0)) ? !low_ff : low_ff;
   assign count_next = !count_en ? COUNT_W'(0)
                     : (count_ff == {COUNT_W{1'b1}}) ? count_ff : count_ff + COUNT_W'(1);
   assign toggle     = count_next >= cfg.change_delay;

   assign out_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      num_in        = num_ff;
      den_in        = den_ff;
      lhs_in        = lhs_ff;
      prod_in       = prod_ff;
      base_in       = base_ff;
      idx_in        = idx_ff;
      level_in      = level_ff;
      prev_level_in = prev_level_ff;
      low_in        = low_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = (req_data.req_type == REQ_DISCONNECT) ? ST_WRITE : ST_SETUP;
            end
         end
         ST_SETUP: begin
            if (win_full <= win_empty) begin
               num_in = '0;
               den_in = MV_W'(1);
            end else begin
               den_in = span;
               if (req_ff.voltage_mv <= win_empty) begin
                  num_in = '0;
               end else if (offset >= span) begin
                  num_in = span;
               end else begin
                  num_in = offset;
               end
            end
            base_in  = '0;
            idx_in   = '0;
            state_in = ST_LHS;
         end
         ST_LHS: begin
            lhs_in   = mul_p;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            prod_in  = mul_p;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (lhs_ff <= prod_ff) begin
               level_in = idx_ff;
               state_in = ST_WRITE;
            end else if (idx_ff == LEVEL_W'(NUM_LEVELS - 1)) begin
               level_in = LEVEL_W'(NUM_LEVELS);
               state_in = ST_WRITE;
            end else begin
               idx_in   = idx_ff + LEVEL_W'(1);
               base_in  = base_ff + SCALE_W'(FULL_PERCENT);
               state_in = ST_MUL;
            end
         end
         ST_WRITE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (req_ff.req_type == REQ_DISCONNECT) begin
                  rsp_data_in.level         = '0;
                  rsp_data_in.level_valid   = 1'b0;
                  rsp_data_in.battery_low   = low_ff;
                  rsp_data_in.state_changed = 1'b0;
               end else begin
                  prev_level_in             = level_ff;
                  count_in                  = count_next;
                  low_in                    = low_ff ^ toggle;
                  rsp_data_in.level         = level_ff;
                  rsp_data_in.level_valid   = 1'b1;
                  rsp_data_in.battery_low   = low_ff ^ toggle;
                  rsp_data_in.state_changed = toggle;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         prev_level_ff <= NO_LEVEL;
         low_ff        <= 1'b0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         prev_level_ff <= prev_level_in;
         low_ff        <= low_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      req_ff      <= req_in;
      num_ff      <= num_in;
      den_ff      <= den_in;
      lhs_ff      <= lhs_in;
      prod_ff     <= prod_in;
      base_ff     <= base_in;
      idx_ff      <= idx_in;
      level_ff    <= level_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* test/battery_level_monitor_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_level_monitor_checker
// Passive checker for the battery level monitor. It watches the register,
// request and report channels and keeps its own copy of the window registers
// and of the level/state tracking. Each accepted request produces one
// expected report; each accepted report is checked field by field against
// the oldest one.
// ----------------------------------------------------------------------------
module battery_level_monitor_checker #(
   parameter int NUM_LEVELS = blm_pkg::NUM_LEVELS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  blm_pkg::blm_req_type            req_data,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  blm_pkg::blm_rsp_type            rsp_data,
   input  logic                            csr_write_en,
   input  logic [blm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [blm_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                              mismatch_count,
   output int                              expected_count
);
   import blm_pkg::*;

   localparam int MAX_REPORTED = 10;

   blm_cfg_type        cfg;
   logic [LEVEL_W-1:0] last_level;
   logic               low_battery;
   logic [COUNT_W-1:0] toggle_count;
   blm_rsp_type        expected_reports [$];

   // Percentage 100*above/span against threshold i*100/NL (+hysteresis),
   // both sides multiplied out so nothing is rounded.
   function automatic logic [LEVEL_W-1:0] quantize_level(
      input logic [MV_W-1:0] v,
      input logic [MV_W-1:0] empty_mv,
      input logic [MV_W-1:0] full_mv
   );
      longint unsigned span;
      longint unsigned above;
      longint unsigned scaled;
      longint unsigned bound;
      if (full_mv <= empty_mv) begin
         span  = 1;
         above = 0;
      end else begin
         span = full_mv - empty_mv;
         if (v <= empty_mv) begin
            above = 0;
         end else if (v - empty_mv >= span) begin
            above = span;
         end else begin
            above = v - empty_mv;
         end
      end
      scaled = FULL_PERCENT * above * NUM_LEVELS;
      for (int i = 0; i < NUM_LEVELS; i++) begin
         bound = FULL_PERCENT * i;
         if (last_level == i) begin
            bound += HYST_PERCENT * NUM_LEVELS;
         end
         if (scaled <= bound * span) begin
            return LEVEL_W'(i);
         end
      end
      return LEVEL_W'(NUM_LEVELS);
   endfunction

   function automatic blm_rsp_type predict_report(input blm_req_type item);
      blm_rsp_type        r;
      logic [LEVEL_W-1:0] lvl;
      logic               counts;
      r = '0;
      // disconnect notice: level unavailable, state untouched
      if (item.req_type == REQ_DISCONNECT) begin
         r.battery_low = low_battery;
         return r;
      end
      if (item.motors_off) begin
         lvl = quantize_level(item.voltage_mv, cfg.empty_standby_mv, cfg.full_standby_mv);
      end else begin
         lvl = quantize_level(item.voltage_mv, cfg.empty_flying_mv, cfg.full_flying_mv);
      end
      last_level = lvl;
      counts = (lvl == 0) ? !low_battery : low_battery;
      if (!counts) begin
         toggle_count = '0;
      end else if (toggle_count != '1) begin
         toggle_count++;
      end
      r.level       = lvl;
      r.level_valid = 1'b1;
      // counter is left alone by the toggle
      if (toggle_count >= cfg.change_delay) begin
         low_battery     = ~low_battery;
         r.state_changed = 1'b1;
      end
      r.battery_low = low_battery;
      return r;
   endfunction

   task automatic note_mismatch(input string what, input logic [31:0] want,
                                input logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTED) begin
         $display("%0t: mismatch on %0s: expected %0d, got %0d", $time, what, want, got);
      end
   endtask

   always @(posedge clock) begin : watch
      blm_rsp_type want;
      if (reset) begin
         cfg.empty_standby_mv = EMPTY_STANDBY_RESET;
         cfg.full_standby_mv  = FULL_STANDBY_RESET;
         cfg.empty_flying_mv  = EMPTY_FLYING_RESET;
         cfg.full_flying_mv   = FULL_FLYING_RESET;
         cfg.change_delay     = CHANGE_DELAY_RESET;
         last_level           = NO_LEVEL;
         low_battery          = 1'b0;
         toggle_count         = '0;
         mismatch_count       = 0;
         expected_reports.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_EMPTY_STANDBY: cfg.empty_standby_mv = csr_wdata;
               CSR_FULL_STANDBY:  cfg.full_standby_mv  = csr_wdata;
               CSR_EMPTY_FLYING:  cfg.empty_flying_mv  = csr_wdata;
               CSR_FULL_FLYING:   cfg.full_flying_mv   = csr_wdata;
               CSR_CHANGE_DELAY:  cfg.change_delay     = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_reports.size() == 0) begin
               note_mismatch("report with no transaction pending", 0, 32'(rsp_data));
            end else begin
               want = expected_reports.pop_front();
               if (want.level !== rsp_data.level) begin
                  note_mismatch("level", want.level, rsp_data.level);
               end
               if (want.level_valid !== rsp_data.level_valid) begin
                  note_mismatch("level_valid", want.level_valid, rsp_data.level_valid);
               end
               if (want.battery_low !== rsp_data.battery_low) begin
                  note_mismatch("battery_low", want.battery_low, rsp_data.battery_low);
               end
               if (want.state_changed !== rsp_data.state_changed) begin
                  note_mismatch("state_changed", want.state_changed, rsp_data.state_changed);
               end
            end
         end
         if (req_valid && !req_stall) begin
            expected_reports.push_back(predict_report(req_data));
         end
      end
      expected_count = expected_reports.size();
   end

endmodule

/* test/battery_level_monitor_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_level_monitor_core_test
// Drives the battery level monitor with directed samples (window edges,
// hysteresis boundaries, low-state entry and exit, disconnect notices) and
// then random phases, each under a new register setting: extreme windows,
// empty windows, narrow windows, zero and maximum delay, a long report
// hold-off and a long counting run under the maximum delay. Both sides idle
// and stall at random. A separate checker predicts and compares every report.
// ----------------------------------------------------------------------------
module battery_level_monitor_core_test;
   import blm_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int LONG_HOLD      = 200;
   localparam int SETTLE_CYCLES  = 40;
   localparam int CSR_LAST       = 2**CSR_INDEX_W - 1;
   localparam int DATA_MAX       = 2**CSR_DATA_W - 1;
   localparam int LONG_RUN       = 120;

   logic                   clock        = 1'b0;
   logic                   reset        = 1'b1;
   logic                   req_valid    = 1'b0;
   logic                   req_stall;
   blm_req_type            req_data     = '0;
   logic                   rsp_valid;
   logic                   rsp_stall    = 1'b0;
   blm_rsp_type            rsp_data;
   logic                   csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index    = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata    = '0;

   int mismatches;
   int outstanding;
   int idle_cycles  = 0;
   bit req_idling   = 1'b1;
   bit rsp_idling   = 1'b1;
   bit hold_pending = 1'b0;
   // current windows, indexed by motors_off; used only to aim the voltages
   int win_empty [2];
   int win_full  [2];

   battery_level_monitor_core dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   battery_level_monitor_checker monitor_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatches),
      .expected_count (outstanding)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_en) begin
         idle_cycles <= 0;
      end else if (idle_cycles < WATCHDOG_LIMIT) begin
         idle_cycles <= idle_cycles + 1;
      end else begin
         $display("Verification failed");
         $finish;
      end
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // report side back-pressure
   initial begin : report_sink
      forever begin
         @(negedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(negedge clock);
            rsp_stall <= 1'b0;
         end else if (!rsp_idling || $urandom_range(0, 99) < 70) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b1;
            repeat (pick_gap()) @(negedge clock);
         end
      end
   end

   // entered and left at a falling edge; valid stays high between back-to-back items
   task automatic send_item(input blm_req_type item);
      int gap;
      gap = req_idling ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data  <= item;
      req_valid <= 1'b1;
      do begin
         @(posedge clock);
      end while (req_stall);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do begin
         @(negedge clock);
      end while (outstanding != 0);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      @(negedge clock);
   endtask

   task automatic configure(input int es, input int fs, input int ef, input int ff,
                            input int dly);
      // occasional write to an unmapped index, must be ignored
      if ($urandom_range(0, 2) == 0) begin
         csr_write(CSR_INDEX_W'(int'(CSR_CHANGE_DELAY)
                                + $urandom_range(1, CSR_LAST - CSR_CHANGE_DELAY)),
                   CSR_DATA_W'($urandom));
      end
      csr_write(CSR_EMPTY_STANDBY, CSR_DATA_W'(es));
      csr_write(CSR_FULL_STANDBY, CSR_DATA_W'(fs));
      csr_write(CSR_EMPTY_FLYING, CSR_DATA_W'(ef));
      csr_write(CSR_FULL_FLYING, CSR_DATA_W'(ff));
      csr_write(CSR_CHANGE_DELAY, CSR_DATA_W'(dly));
      csr_write_en <= 1'b0;
      win_empty[1] = es;
      win_full[1]  = fs;
      win_empty[0] = ef;
      win_full[0]  = ff;
   endtask

   task automatic random_config();
      int e [2];
      int f [2];
      int dly;
      int r;
      for (int w = 0; w < 2; w++) begin
         case ($urandom_range(0, 7))
            0, 1, 2, 3: begin
               e[w] = $urandom_range(2500, 3600);
               f[w] = e[w] + $urandom_range(100, 1500);
            end
            4: begin
               e[w] = $urandom_range(0, DATA_MAX - 40);
               f[w] = e[w] + $urandom_range(0, 40);
            end
            5: begin
               e[w] = $urandom_range(0, DATA_MAX);
               f[w] = $urandom_range(0, e[w]);
            end
            default: begin
               e[w] = $urandom_range(0, DATA_MAX);
               f[w] = $urandom_range(0, DATA_MAX);
            end
         endcase
      end
      r = $urandom_range(0, 19);
      if (r < 14) dly = $urandom_range(0, 6);
      else if (r < 17) dly = $urandom_range(7, 40);
      else dly = $urandom_range(0, DATA_MAX);
      configure(e[1], f[1], e[0], f[0], dly);
   endtask

   function automatic blm_req_type sample_item(input int v, input bit off);
      blm_req_type item;
      item.req_type   = REQ_SAMPLE;
      item.voltage_mv = MV_W'(v);
      item.motors_off = off;
      return item;
   endfunction

   function automatic blm_req_type notice_item();
      blm_req_type item;
      item.req_type   = REQ_DISCONNECT;
      item.voltage_mv = MV_W'($urandom_range(0, DATA_MAX));
      item.motors_off = 1'($urandom_range(0, 1));
      return item;
   endfunction

   // voltage aimed at one part of the selected window
   function automatic int pick_voltage(input bit off, input int shape);
      int e;
      int f;
      int span;
      int lo;
      int hi;
      int k;
      e    = win_empty[off];
      f    = win_full[off];
      span = f - e;
      if (shape == 9 || span <= 0) return $urandom_range(0, DATA_MAX);
      case (shape)
         0, 1, 2: begin
            lo = e - 20;
            hi = e + span / 8;
         end
         3, 4: begin
            lo = f - span / 8;
            hi = f + 20;
         end
         8: begin
            // around a level threshold, with or without the hysteresis step
            k  = $urandom_range(0, 10);
            lo = e + span * (10 * k + 2 * $urandom_range(0, 1)) / 100 - 2;
            hi = lo + 4;
         end
         default: begin
            lo = e - span / 20 - 1;
            hi = f + span / 20 + 1;
         end
      endcase
      if (lo < 0) lo = 0;
      if (hi > DATA_MAX) hi = DATA_MAX;
      if (lo > hi) lo = hi;
      return $urandom_range(hi, lo);
   endfunction

   // runs of samples in one region of the window, so the state counter moves
   task automatic run_random(input int count);
      int left;
      int run_len;
      int shape;
      bit off;
      left = count;
      while (left > 0) begin
         run_len = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 14) : $urandom_range(1, 5);
         shape   = $urandom_range(0, 9);
         off     = 1'($urandom_range(0, 1));
         repeat (run_len) begin
            if ($urandom_range(0, 19) == 0) begin
               send_item(notice_item());
            end else begin
               if ($urandom_range(0, 9) == 0) off = ~off;
               send_item(sample_item(pick_voltage(off, shape), off));
            end
            left--;
         end
      end
   endtask

   initial begin : stimulus
      win_empty[1] = EMPTY_STANDBY_RESET;
      win_full[1]  = FULL_STANDBY_RESET;
      win_empty[0] = EMPTY_FLYING_RESET;
      win_full[0]  = FULL_FLYING_RESET;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // directed, reset register values
      send_item(notice_item());
      send_item(sample_item(0, 1));
      send_item(sample_item(DATA_MAX, 0));
      send_item(sample_item(3300, 1));
      // hysteresis keeps level 3 up to exactly 32 percent
      send_item(sample_item(3372, 1));
      send_item(sample_item(3384, 1));
      send_item(sample_item(3385, 1));
      send_item(sample_item(3120, 1));
      send_item(sample_item(3121, 1));
      send_item(sample_item(0, 0));
      send_item(sample_item(DATA_MAX, 1));
      repeat (5) send_item(sample_item(EMPTY_FLYING_RESET, 0));
      send_item(notice_item());
      send_item(sample_item(EMPTY_FLYING_RESET, 0));
      repeat (5) send_item(sample_item(FULL_STANDBY_RESET, 1));

      // widest windows, zero delay
      wait_drained();
      configure(0, DATA_MAX, 0, DATA_MAX, 0);
      run_random(100);

      // empty windows, longest delay
      wait_drained();
      configure(DATA_MAX, 0, 1000, 1000, DATA_MAX);
      run_random(60);

      // narrow windows: thresholds fall between millivolt steps
      wait_drained();
      configure(3000, 3001, 2900, 2907, 1);
      run_random(100);

      // reports held off for a long stretch while requests keep coming
      wait_drained();
      random_config();
      req_idling   = 1'b0;
      hold_pending = 1'b1;
      run_random(60);
      req_idling = 1'b1;

      for (int p = 0; p < 8; p++) begin
         wait_drained();
         random_config();
         req_idling = ($urandom_range(0, 3) != 0);
         rsp_idling = ($urandom_range(0, 3) != 0);
         run_random(110);
      end

      // bring the state to normal with a cleared counter, then count for a long run
      wait_drained();
      req_idling = 1'b0;
      rsp_idling = 1'b0;
      configure(EMPTY_STANDBY_RESET, FULL_STANDBY_RESET, EMPTY_FLYING_RESET,
                FULL_FLYING_RESET, 1);
      repeat (2) send_item(sample_item(DATA_MAX, 0));
      wait_drained();
      configure(EMPTY_STANDBY_RESET, FULL_STANDBY_RESET, EMPTY_FLYING_RESET,
                FULL_FLYING_RESET, DATA_MAX);
      repeat (LONG_RUN) send_item(sample_item(0, 1'($urandom_range(0, 1))));
      // alternating empty and full samples clear the counter every other item
      for (int n = 0; n < 6; n++) begin
         send_item(sample_item((n % 2) ? 0 : DATA_MAX, 1));
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
